### rtl/core/pdp11_opcode_mnemonic_decoder_defines.svh
// ----------------------------------------------------------------------------
// pdp11 opcode mnemonic decoder assertion macros
// shared property shorthands, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PDP11_OPCODE_MNEMONIC_DECODER_DEFINES_SVH
`define PDP11_OPCODE_MNEMONIC_DECODER_DEFINES_SVH

// same-cycle implication
`define POMD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define POMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// implication with the consequent delayed after the antecedent
`define POMD_ASSERT_DLY2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

### rtl/core/pomd_pkg.sv
// ----------------------------------------------------------------------------
// pomd_pkg
// mnemonic codes and opcode field constants for the pdp11 opcode decoder
// ----------------------------------------------------------------------------
package pomd_pkg;

  // dense mnemonic index, unknown last
  typedef enum logic [6:0] {
    MN_JSR, MN_SOB, MN_BR, MN_BNE, MN_BEQ, MN_BGE, MN_BLT, MN_BGT, MN_BLE,
    MN_JMP, MN_SWAB, MN_CLR, MN_COM, MN_INC, MN_DEC, MN_NEG, MN_ADC, MN_SBC,
    MN_TST, MN_ROR, MN_ROL, MN_ASR, MN_ASL, MN_MARK, MN_MFPI, MN_MTPI, MN_SXT,
    MN_FLAG, MN_RTS, MN_SPL, MN_HALT, MN_WAIT, MN_RTI, MN_BPT, MN_IOT, MN_RSET,
    MN_RTT, MN_MOV, MN_CMP, MN_BIT, MN_BIC, MN_BIS, MN_ADD, MN_MUL, MN_DIV,
    MN_ASH, MN_ASHC, MN_XOR, MN_BPL, MN_BMI, MN_BHI, MN_BLOS, MN_BVC, MN_BVS,
    MN_BHIS, MN_BLO, MN_EMT, MN_SYS, MN_CLRB, MN_COMB, MN_INCB, MN_DECB,
    MN_NEGB, MN_ADCB, MN_SBCB, MN_TSTB, MN_RORB, MN_ROLB, MN_ASRB, MN_ASLB,
    MN_MFPD, MN_MTPD, MN_MOVB, MN_CMPB, MN_BITB, MN_BICB, MN_BISB, MN_SUB,
    MN_UNKNOWN
  } mnem_e;

  typedef struct packed {
    mnem_e code;
    logic  known;
  } dec_t;

  // top octal digit groups
  localparam logic [3:0] GRP_SYS  = 4'o00;
  localparam logic [3:0] GRP_MOV  = 4'o01;
  localparam logic [3:0] GRP_ADD  = 4'o06;
  localparam logic [3:0] GRP_EIS  = 4'o07;
  localparam logic [3:0] GRP_BYTE = 4'o10;
  localparam logic [3:0] GRP_MOVB = 4'o11;
  localparam logic [3:0] GRP_SUB  = 4'o16;
  localparam logic [3:0] GRP_FP   = 4'o17;

  // group 00 fields
  localparam logic [2:0]  F3_JSR  = 3'o4;   // bits 11:9
  localparam logic [3:0]  BR_LO   = 4'd1;   // bits 11:8
  localparam logic [3:0]  BR_HI   = 4'd7;
  localparam logic [5:0]  F6_JMP  = 6'o01;  // bits 11:6
  localparam logic [5:0]  F6_SWAB = 6'o03;
  localparam logic [5:0]  F6_CLR  = 6'o50;
  localparam logic [5:0]  F6_SXT  = 6'o67;
  localparam logic [6:0]  F7_FLAG = 7'o005; // bits 11:5
  localparam logic [8:0]  F9_RTS  = 9'o020; // bits 11:3
  localparam logic [8:0]  F9_SPL  = 9'o023;
  localparam logic [11:0] F12_RTT = 12'o0006; // last exact-match word

  // group 07 fields, bits 11:9
  localparam logic [2:0] F3_MUL = 3'o0;
  localparam logic [2:0] F3_XOR = 3'o4;
  localparam logic [2:0] F3_SOB = 3'o7;

  // group 10 fields
  localparam logic [3:0] BX_LO   = 4'd0;    // bits 11:8, bpl .. sys
  localparam logic [3:0] BX_HI   = 4'd9;
  localparam logic [5:0] F6_CLRB = 6'o50;   // bits 11:6
  localparam logic [5:0] F6_ASLB = 6'o63;
  localparam logic [5:0] F6_MFPD = 6'o65;
  localparam logic [5:0] F6_MTPD = 6'o66;

  localparam logic [15:0] WORD_MTPD = 16'o106600;

endpackage

### rtl/core/pomd_decode.sv
// ----------------------------------------------------------------------------
// pomd_decode
// masked pattern match of one instruction word to a mnemonic code
// ----------------------------------------------------------------------------
module pomd_decode (
  input  logic [15:0]    word_i,
  output pomd_pkg::dec_t dec_o
);
  import pomd_pkg::*;

  logic [3:0] grp;
  logic [2:0] f3;
  logic [3:0] f4;
  logic [5:0] f6;
  mnem_e      code;

  assign grp = word_i[15:12];
  assign f3  = word_i[11:9];
  assign f4  = word_i[11:8];
  assign f6  = word_i[11:6];

  // the patterns within each group are disjoint, so the checks need no ordering
  always_comb begin
    code = MN_UNKNOWN;
    case (grp)
      GRP_SYS: begin
        if (f3 == F3_JSR) begin
          code = MN_JSR;
        end
        if (f4 inside {[BR_LO:BR_HI]}) begin
          code = mnem_e'(7'(MN_BR) + 7'(f4 - BR_LO));
        end
        if (f6 == F6_JMP) begin
          code = MN_JMP;
        end
        if (f6 == F6_SWAB) begin
          code = MN_SWAB;
        end
        if (f6 inside {[F6_CLR:F6_SXT]}) begin
          code = mnem_e'(7'(MN_CLR) + 7'(f6 - F6_CLR));
        end
        if (word_i[11:5] == F7_FLAG) begin
          code = MN_FLAG;
        end
        if (word_i[11:3] == F9_RTS) begin
          code = MN_RTS;
        end
        if (word_i[11:3] == F9_SPL) begin
          code = MN_SPL;
        end
        if (word_i[11:0] <= F12_RTT) begin
          code = mnem_e'(7'(MN_HALT) + 7'(word_i[2:0]));
        end
      end
      GRP_EIS: begin
        if (f3 <= F3_XOR) begin
          code = mnem_e'(7'(MN_MUL) + 7'(f3 - F3_MUL));
        end else if (f3 == F3_SOB) begin
          code = MN_SOB;
        end
      end
      GRP_BYTE: begin
        if (f4 inside {[BX_LO:BX_HI]}) begin
          code = mnem_e'(7'(MN_BPL) + 7'(f4 - BX_LO));
        end
        if (f6 inside {[F6_CLRB:F6_ASLB]}) begin
          code = mnem_e'(7'(MN_CLRB) + 7'(f6 - F6_CLRB));
        end
        if (f6 == F6_MFPD) begin
          code = MN_MFPD;
        end
        if (f6 == F6_MTPD) begin
          code = MN_MTPD;
        end
      end
      GRP_FP: begin
        code = MN_UNKNOWN;
      end
      default: begin
        if (grp inside {[GRP_MOV:GRP_ADD]}) begin
          code = mnem_e'(7'(MN_MOV) + 7'(grp - GRP_MOV));
        end else if (grp inside {[GRP_MOVB:GRP_SUB]}) begin
          code = mnem_e'(7'(MN_MOVB) + 7'(grp - GRP_MOVB));
        end
      end
    endcase
  end

  assign dec_o.code  = code;
  assign dec_o.known = (code != MN_UNKNOWN);

endmodule

### rtl/core/pdp11_opcode_mnemonic_decoder.sv
// ----------------------------------------------------------------------------
// pdp11_opcode_mnemonic_decoder
// classifies pdp11 instruction words into a dense mnemonic code
// ----------------------------------------------------------------------------
// A word beat is taken on any edge where start_i is high and busy_o is low.
// busy_o is high during reset and in the first cycle after reset is released,
// and low from then on, so one word can be issued every cycle. The word is
// latched into an input register, decoded by a single level of masked compares
// and registered again: the result shows on mnemonic_code_o / known_o with
// done_o high for exactly one cycle, once the result register has taken the
// decoded word, and is taken at the edge that ends that cycle.
// Results leave in issue order and there is no way to stall them, so the
// receiver must take every done_o beat as it comes. Words with no matching
// pattern (including every word whose top octal digit is 17) give the
// unknown code with known_o low.
// ----------------------------------------------------------------------------
`include "pdp11_opcode_mnemonic_decoder_defines.svh"

module pdp11_opcode_mnemonic_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] instr_word_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [6:0]  mnemonic_code_o,
  output logic        known_o
);
  import pomd_pkg::*;

  // control state
  logic busy_q, busy_d;
  logic vld_q, vld_d;
  logic done_q, done_d;

  // payload
  logic [15:0] word_q, word_d;
  dec_t        res_q, res_d;

  logic accept;
  dec_t dec;

  // assertion helpers
  logic code_unknown;
  logic word_is_fp;
  logic word_is_mtpd;

  // issue handshake
  assign accept = start_i && !busy_q;

  // busy only covers the cycle right after reset release
  assign busy_d = 1'b0;

  // stage 1: input register
  assign vld_d  = accept;
  assign word_d = accept ? instr_word_i : word_q;

  // decode between the two registers
  pomd_decode u_decode (
    .word_i (word_q),
    .dec_o  (dec)
  );

  // stage 2: result register, one strobe per latched word
  assign done_d = vld_q;
  assign res_d  = vld_q ? dec : res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      vld_q  <= vld_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    res_q  <= res_d;
  end

  assign busy_o          = busy_q;
  assign done_o          = done_q;
  assign mnemonic_code_o = res_q.code;
  assign known_o         = res_q.known;

  assign code_unknown = (mnemonic_code_o == 7'(MN_UNKNOWN));
  assign word_is_fp   = (word_q[15:12] == GRP_FP);
  assign word_is_mtpd = (word_q == WORD_MTPD);

  // every accepted beat comes out through both registers
  `POMD_ASSERT_DLY2(a_accept_to_done, accept, done_o, "accepted word gave no result beat")

  // once ready, the block stays ready
  `POMD_ASSERT_NEXT(a_busy_stays_low, !busy_o, !busy_o, "busy rose after reset release")

  // known flag agrees with the code
  `POMD_ASSERT_IMPL(a_known_code, done_o, known_o == !code_unknown, "known flag and code disagree")

  // group 17 is never recognized
  `POMD_ASSERT_IMPL(a_grp_fp_unknown, done_o && $past(word_is_fp), !known_o, "group 17 decoded")

  // the mtpd word is not taken for mfpd
  `POMD_ASSERT_IMPL(a_mtpd, done_o && $past(word_is_mtpd), res_q.code == MN_MTPD, "mtpd misread")

endmodule
